// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the checker file rmd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion, checked during reset too.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/rmd_pkg.sv -----
package rmd_pkg;

  localparam int unsigned LenWidth = 31;
  localparam int unsigned ShiftWidth = 24;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY_END = 2'd1;
  localparam logic [1:0] KIND_TRAILING = 2'd2;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic [1:0] HDR_LAST_COUNT = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       fragment_end;
    logic       record_end;
  } result_t;

endpackage

// ----- rtl/core/rmd_in_if.sv -----
interface rmd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink (input valid, input action, input in_byte, output ready);
endinterface

// ----- rtl/core/rmd_out_if.sv -----
interface rmd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       fragment_end;
  logic       record_end;

  modport source (output valid, output out_kind, output out_byte,
                  output fragment_end, output record_end, input ready);
  modport sink (input valid, input out_kind, input out_byte,
                input fragment_end, input record_end, output ready);
endinterface

// ----- rtl/core/rmd_step.sv -----
module rmd_step
  import rmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       action,
  input  logic [7:0] in_byte,
  output result_t    res
);

  phase_t                phase, phase_next;
  logic [1:0]            header_count, header_count_next;
  logic [ShiftWidth-1:0] header_shift, header_shift_next;
  logic                  last_frag_flag, last_frag_flag_next;
  logic [LenWidth-1:0]   payload_left, payload_left_next;

  logic [LenWidth-1:0]   hdr_len;
  logic                  hdr_last;
  logic                  hdr_done;
  logic                  pay_last;

  assign hdr_len  = {header_shift[ShiftWidth-2:0], in_byte};
  assign hdr_last = header_shift[ShiftWidth-1];
  assign hdr_done = (header_count == HDR_LAST_COUNT);
  assign pay_last = (payload_left == LenWidth'(1));

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEADER: begin
        if (action == ACT_BYTE && hdr_done) begin
          if (hdr_len == '0) begin
            phase_next = hdr_last ? PH_DONE : PH_HEADER;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (action == ACT_BYTE && pay_last) begin
          phase_next = last_frag_flag ? PH_DONE : PH_HEADER;
        end
      end
      PH_DONE: begin
        if (action == ACT_RESTART) begin
          phase_next = PH_HEADER;
        end
      end
      default: phase_next = PH_HEADER;
    endcase
  end

  always_comb begin
    header_count_next   = header_count;
    header_shift_next   = header_shift;
    last_frag_flag_next = last_frag_flag;
    payload_left_next   = payload_left;
    res                 = '0;
    res.out_byte        = in_byte;
    unique case (phase)
      PH_HEADER: begin
        if (action == ACT_BYTE) begin
          if (!hdr_done) begin
            header_shift_next = {header_shift[ShiftWidth-9:0], in_byte};
            header_count_next = header_count + 2'd1;
          end else begin
            header_count_next = '0;
            header_shift_next = '0;
            if (hdr_len == '0) begin
              last_frag_flag_next = 1'b0;
              payload_left_next   = '0;
              if (hdr_last) begin
                res.valid        = 1'b1;
                res.out_kind     = KIND_EMPTY_END;
                res.out_byte     = '0;
                res.fragment_end = 1'b1;
                res.record_end   = 1'b1;
              end
            end else begin
              last_frag_flag_next = hdr_last;
              payload_left_next   = hdr_len;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        if (action == ACT_BYTE) begin
          res.valid         = 1'b1;
          res.out_kind      = KIND_PAYLOAD;
          payload_left_next = payload_left - LenWidth'(1);
          if (pay_last) begin
            res.fragment_end    = 1'b1;
            res.record_end      = last_frag_flag;
            last_frag_flag_next = 1'b0;
          end
        end
      end
      PH_DONE: begin
        if (action == ACT_BYTE) begin
          res.valid    = 1'b1;
          res.out_kind = KIND_TRAILING;
        end else begin
          header_count_next   = '0;
          header_shift_next   = '0;
          last_frag_flag_next = 1'b0;
          payload_left_next   = '0;
        end
      end
      default: res.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= '0;
      header_shift   <= '0;
      last_frag_flag <= 1'b0;
      payload_left   <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      header_shift   <= header_shift_next;
      last_frag_flag <= last_frag_flag_next;
      payload_left   <= payload_left_next;
    end
  end

endmodule

// ----- rtl/core/rmd_out_reg.sv -----
module rmd_out_reg
  import rmd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  result_t      res,
  output logic         free,
  rmd_out_if.source    result
);

  logic       valid;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       fragment_end;
  logic       record_end;

  assign free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load && res.valid) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      out_kind     <= res.out_kind;
      out_byte     <= res.out_byte;
      fragment_end <= res.fragment_end;
      record_end   <= res.record_end;
    end
  end

  assign result.valid        = valid;
  assign result.out_kind     = out_kind;
  assign result.out_byte     = out_byte;
  assign result.fragment_end = fragment_end;
  assign result.record_end   = record_end;

endmodule

// ----- rtl/core/record_marking_deframer.sv -----
// An accepted word's result, if any, is registered before it reaches the output.
// Throughput: one word per cycle while the result register is free; it frees
// itself in the same cycle the sink takes its word, so input ready follows
// output ready. Reset (rst, synchronous, active high): header phase, counters and
// length cleared, result register empty.
module record_marking_deframer
  import rmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  rmd_in_if.sink     stream,
  rmd_out_if.source  result
);

  result_t res;
  logic    free;
  logic    accept;

  assign stream.ready = free;
  assign accept       = stream.valid && free;

  rmd_step u_step (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .action  (stream.action),
    .in_byte (stream.in_byte),
    .res     (res)
  );

  rmd_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .res    (res),
    .free   (free),
    .result (result)
  );

endmodule

// ----- rtl/core/rmd_checker.sv -----
`include "assert_macros.svh"

module rmd_checker
  import rmd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       fragment_end,
  input logic       record_end
);

  `ASSERT_CLK(a_empty_end, (out_valid && out_kind == KIND_EMPTY_END) |-> (fragment_end && record_end && out_byte == 8'd0), "empty end marker malformed")
  `ASSERT_CLK(a_trailing, (out_valid && out_kind == KIND_TRAILING) |-> (!fragment_end && !record_end), "trailing error carries end flags")
  `ASSERT_CLK(a_rec_frag, (out_valid && record_end) |-> fragment_end, "record end without fragment end")
  `ASSERT_CLK(a_ready, (!out_valid || out_ready) |-> in_ready, "input stalled with free output")
  `ASSERT_CLK(a_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) && $stable(out_byte) && $stable(fragment_end) && $stable(record_end)), "stalled word changed")

endmodule

bind record_marking_deframer rmd_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (stream.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_kind     (result.out_kind),
  .out_byte     (result.out_byte),
  .fragment_end (result.fragment_end),
  .record_end   (result.record_end)
);
